// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the double-ended queue unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// The consequent holds at the same edge as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, command and status codes, and ring pointer helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Ring store size and derived widths.
  localparam int DEPTH  = 16;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int OCC_W  = 5;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] count_t;
  typedef logic signed [VAL_W-1:0] value_t;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Advance a ring pointer by one entry, wrapping at the top of the store.
  function automatic ptr_t ptr_inc(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Step a ring pointer back by one entry, wrapping at the bottom.
  function automatic ptr_t ptr_dec(input ptr_t p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

endpackage

// File: design/deq_if.sv
// ----------------------------------------------------------------------------
// Double-ended queue channels
// Command and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Command channel: one item is one queue command.
interface deq_req_if;
  import deq_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   cmd;
  value_t push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

// Response channel: one item per command.
interface deq_rsp_if;
  import deq_pkg::*;

  logic             valid;
  logic             ready;
  value_t           pop_value;
  status_t          status;
  logic [OCC_W-1:0] occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

// File: design/deq_ram.sv
// ----------------------------------------------------------------------------
// Double-ended queue entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram (
  input  logic          clk,
  input  logic          wr_en,
  input  deq_pkg::ptr_t wr_addr,
  input  deq_pkg::value_t wr_data,
  input  logic          rd_en,
  input  deq_pkg::ptr_t rd_addr,
  output deq_pkg::value_t rd_data
);
  import deq_pkg::*;

  value_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/double_ended_queue_unit.sv
// Latency: a command accepted at one edge has its response registered at the next edge,
// later only while the previous response waits on the response channel.
// A new command is taken only in the idle state, once the previous one has finished.
// Reset: synchronous and active high; empties the queue and clears both pointers.
// Entries are not cleared; a pop only returns entries that a push has written.
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Ring store with front and back pointers, push and pop at either end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_ended_queue_unit (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  state_t  state;
  state_t  state_next;
  ptr_t    front_ptr;
  ptr_t    front_ptr_next;
  ptr_t    back_ptr;
  ptr_t    back_ptr_next;
  count_t  fill_count;
  count_t  fill_count_next;
  cmd_t    cmd_q;
  value_t  value_q;
  logic    rsp_valid;

  logic    accept;
  logic    out_free;
  logic    finish;
  logic    is_push;
  logic    full;
  logic    empty;
  logic    rd_en;
  ptr_t    rd_addr;
  value_t  rd_data;
  logic    wr_en;
  ptr_t    wr_addr;
  status_t status_c;
  value_t  pop_c;
  ptr_t    ring_end;

  // Handshake on both channels.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !rsp_valid || rsp.ready;
  assign finish    = (state == S_EXEC) && out_free;
  assign rsp.valid = rsp_valid;

  // Read at accept time: the front entry, or the entry just below the back pointer.
  // A write from an earlier command lands at its finish edge, before any later read.
  assign rd_en   = accept;
  assign rd_addr = (req.cmd == CMD_POP_BACK) ? ptr_dec(back_ptr) : front_ptr;

  deq_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Command execution: status, popped value, store write and pointer updates.
  always_comb begin
    is_push         = (cmd_q == CMD_PUSH_FRONT) || (cmd_q == CMD_PUSH_BACK);
    full            = (fill_count == CNT_W'(DEPTH));
    empty           = (fill_count == '0);
    status_c        = ST_OK;
    pop_c           = '0;
    wr_en           = 1'b0;
    wr_addr         = back_ptr;
    front_ptr_next  = front_ptr;
    back_ptr_next   = back_ptr;
    fill_count_next = fill_count;
    if (is_push && full) begin
      status_c = ST_OVERFLOW;
    end else if (!is_push && empty) begin
      status_c = ST_UNDERFLOW;
    end else begin
      case (cmd_q)
        CMD_PUSH_FRONT: begin
          front_ptr_next  = ptr_dec(front_ptr);
          wr_addr         = front_ptr_next;
          wr_en           = finish;
          fill_count_next = fill_count + 1'b1;
        end
        CMD_PUSH_BACK: begin
          wr_addr         = back_ptr;
          wr_en           = finish;
          back_ptr_next   = ptr_inc(back_ptr);
          fill_count_next = fill_count + 1'b1;
        end
        CMD_POP_FRONT: begin
          pop_c           = rd_data;
          front_ptr_next  = ptr_inc(front_ptr);
          fill_count_next = fill_count - 1'b1;
        end
        CMD_POP_BACK: begin
          pop_c           = rd_data;
          back_ptr_next   = ptr_dec(back_ptr);
          fill_count_next = fill_count - 1'b1;
        end
        default: begin
          status_c = ST_OK;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front_ptr  <= '0;
      back_ptr   <= '0;
      fill_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        front_ptr  <= front_ptr_next;
        back_ptr   <= back_ptr_next;
        fill_count <= fill_count_next;
        rsp_valid  <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Captured command and response payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= req.cmd;
      value_q <= req.push_value;
    end
    if (finish) begin
      rsp.pop_value <= pop_c;
      rsp.status    <= status_c;
      rsp.occupancy <= OCC_W'(fill_count_next);
    end
  end

  // Where the back pointer must sit for the current front pointer and fill count.
  always_comb begin
    if ((CNT_W + 1)'(front_ptr) + (CNT_W + 1)'(fill_count) >= (CNT_W + 1)'(DEPTH)) begin
      ring_end = PTR_W'((CNT_W + 1)'(front_ptr) + (CNT_W + 1)'(fill_count)
                        - (CNT_W + 1)'(DEPTH));
    end else begin
      ring_end = PTR_W'((CNT_W + 1)'(front_ptr) + (CNT_W + 1)'(fill_count));
    end
  end

  // The fill count never passes the store size.
  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= CNT_W'(DEPTH))
  // Back pointer stays one past the last entry counted from the front.
  `ASSERT_ALWAYS(a_ptr_consistent, clk, rst, back_ptr == ring_end)
  // An overflow is only reported with the store full.
  `ASSERT_IMPLIES(a_overflow_full, clk, rst, rsp.valid && rsp.status == ST_OVERFLOW,
                  rsp.occupancy == OCC_W'(DEPTH))
  // An underflow leaves the queue empty and returns zero.
  `ASSERT_IMPLIES(a_underflow_empty, clk, rst, rsp.valid && rsp.status == ST_UNDERFLOW,
                  rsp.occupancy == '0 && rsp.pop_value == '0)
  // A command in flight always yields a response at the next edge when the output is free.
  `ASSERT_NEXT(a_finish_resp, clk, rst, finish, rsp.valid && state == S_IDLE)

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives push and pop commands at both ends of the queue, predicts every
// response from a local ring model, and checks each response field by field
// under phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  // Cycles with no item accepted on either channel before the run is abandoned.
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 6;
  // Slots in the ring of predicted responses; far more than can be pending.
  localparam int EXP_DEPTH    = 1024;

  typedef struct {
    value_t           pop_value;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } deq_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  deq_req_if req_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Local copy of the deque contents and pointers.
  value_t ring_mem [DEPTH];
  int     front_idx;
  int     back_idx;
  int     fill_level;

  // Predicted responses in order, kept in a ring with write and read counts.
  deq_result_t exp_mem [EXP_DEPTH];
  int          exp_wr;
  int          exp_rd;
  int          mismatch_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  always #5 clk = ~clk;

  // Record one failure; only the first few are described.
  function automatic void log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Number of predicted responses not yet seen.
  function automatic int pending_count();
    return exp_wr - exp_rd;
  endfunction

  // Append one predicted response.
  function automatic void store_expected(input deq_result_t r);
    exp_mem[exp_wr % EXP_DEPTH] = r;
    exp_wr++;
  endfunction

  // Apply one accepted command to the local deque and queue its response.
  function automatic void predict_deque(input cmd_t c, input value_t v);
    deq_result_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    case (c)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (c == CMD_PUSH_FRONT) begin
          front_idx = (front_idx + DEPTH - 1) % DEPTH;
          ring_mem[front_idx] = v;
          fill_level++;
        end else begin
          ring_mem[back_idx] = v;
          back_idx = (back_idx + 1) % DEPTH;
          fill_level++;
        end
      end
      default: begin
        if (fill_level == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (c == CMD_POP_FRONT) begin
          r.pop_value = ring_mem[front_idx];
          front_idx = (front_idx + 1) % DEPTH;
          fill_level--;
        end else begin
          back_idx = (back_idx + DEPTH - 1) % DEPTH;
          r.pop_value = ring_mem[back_idx];
          fill_level--;
        end
      end
    endcase
    r.occupancy = OCC_W'(fill_level);
    store_expected(r);
  endfunction

  // Values now and then take the extremes of the signed range, zero or minus one.
  function automatic value_t pick_value();
    case ($urandom_range(7))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Present one command, idling first at random, and wait until it is taken.
  task automatic send_command(input cmd_t c, input value_t v);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= c;
    req_ch.push_value <= v;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    predict_deque(c, v);
  endtask

  // Receiver side: ready is redrawn every cycle.
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted response with the oldest prediction.
  always @(posedge clk) begin
    deq_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_count() == 0) begin
        log_mismatch($sformatf("response with none pending: pop_value=%0d st=%0d occ=%0d",
                               rsp_ch.pop_value, rsp_ch.status, rsp_ch.occupancy));
      end else begin
        exp_r = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (rsp_ch.pop_value !== exp_r.pop_value || rsp_ch.status !== exp_r.status ||
            rsp_ch.occupancy !== exp_r.occupancy) begin
          log_mismatch($sformatf(
            "pop_value exp=%0d got=%0d, st exp=%0d got=%0d, occ exp=%0d got=%0d",
            exp_r.pop_value, rsp_ch.pop_value, exp_r.status, rsp_ch.status,
            exp_r.occupancy, rsp_ch.occupancy));
        end
      end
    end
  end

  // Watchdog: give up when neither channel moves an item for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // Pops on an empty deque at both ends report underflow.
  task automatic test_underflow();
    send_command(CMD_POP_FRONT, 32'sh7fff_ffff);
    send_command(CMD_POP_BACK, 32'sh8000_0000);
  endtask

  // Pushes and pops at both ends check ordering and the extreme values.
  task automatic test_both_ends();
    send_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'sh8000_0000);
    send_command(CMD_PUSH_FRONT, '0);
    send_command(CMD_PUSH_BACK, -32'sd1);
    send_command(CMD_POP_FRONT, -32'sd1);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_POP_FRONT, 32'sh5555_5555);
    send_command(CMD_POP_BACK, 32'shaaaa_aaaa);
    // A value pushed at one end and popped at the other.
    send_command(CMD_PUSH_FRONT, 32'sh1234_5678);
    send_command(CMD_POP_BACK, '0);
    send_command(CMD_PUSH_BACK, 32'shedcb_a987);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
  endtask

  // Random traffic in stretches that lean toward pushes, balance, or pops,
  // so the deque fills to overflow and drains to underflow repeatedly.
  task automatic test_random_traffic(input int n_items, input int idle_pct,
                                     input int stall_pct);
    int push_pct;
    int picked;
    cmd_t c;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    push_pct = 85;
    for (int i = 0; i < n_items; i++) begin
      if (i % 24 == 0) begin
        picked = $urandom_range(2);
        push_pct = (picked == 0) ? 85 : (picked == 1) ? 50 : 15;
      end
      if ($urandom_range(99) < push_pct) begin
        c = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else begin
        c = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end
      send_command(c, pick_value());
    end
  endtask

  // Reset, directed checks, random phases, then drain and report.
  initial begin
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_PUSH_FRONT;
    req_ch.push_value = '0;
    rsp_ch.ready      = 1'b0;
    front_idx      = 0;
    back_idx       = 0;
    fill_level     = 0;
    exp_wr         = 0;
    exp_rd         = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_underflow();
    test_both_ends();
    test_random_traffic(110, 0, 0);
    test_random_traffic(110, 71, 0);
    test_random_traffic(110, 0, 71);
    test_random_traffic(110, 17, 17);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_count() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_count() != 0) begin
      log_mismatch("responses still pending at the end");
    end

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
